>>> rtl/rpf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rpf_pkg: shared types and constants for the radio packet framer
// Command, result and status codes, the result descriptor and the CRC-16
// byte update.
// ---------------------------------------------------------------------------
package rpf_pkg;

	// command codes
	localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TX_START = 2'd1;
	localparam logic [1:0] CMD_TX_BYTE  = 2'd2;
	localparam logic [1:0] CMD_ABORT    = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_RX_PAY = 2'd1;
	localparam logic [1:0] KIND_FEND   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CRC_ERR = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_BAD_LEN = 3'd3;
	localparam logic [2:0] ST_BUSY_TX = 3'd4;
	localparam logic [2:0] ST_BUSY_RX = 3'd5;
	localparam logic [2:0] ST_TOO_BIG = 3'd6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] PREAMBLE = 8'hAA;
	localparam logic [7:0] SYNC_HI  = 8'h2D;
	localparam logic [7:0] SYNC_LO  = 8'hD4;

	// slots of the transmit line sequence
	localparam logic [3:0] POS_PRE0   = 4'd0;
	localparam logic [3:0] POS_SYNC_H = 4'd3;
	localparam logic [3:0] POS_SYNC_L = 4'd4;
	localparam logic [3:0] POS_LEN    = 4'd5;
	localparam logic [3:0] POS_PAY    = 4'd6;
	localparam logic [3:0] POS_CRC_LO = 4'd7;
	localparam logic [3:0] POS_CRC_HI = 4'd8;
	localparam logic [3:0] POS_TAIL1  = 4'd10;

	// one burst of results caused by one request
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;      // length byte, echoed or received payload byte
		logic [2:0]  status;
		logic [7:0]  plen;
		logic [15:0] crc;       // CRC sent in the tail
		logic [3:0]  pos_start;
		logic [3:0]  pos_end;
		logic        skip_pay;  // header followed directly by tail
	} rpf_desc_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
		end
		return v;
	endfunction

	function automatic logic [7:0] line_byte(input logic [3:0] pos, input rpf_desc_t d);
		logic [7:0] r;
		case (pos)
			POS_SYNC_H: r = SYNC_HI;
			POS_SYNC_L: r = SYNC_LO;
			POS_LEN:    r = d.data;
			POS_PAY:    r = d.data;
			POS_CRC_LO: r = d.crc[7:0];
			POS_CRC_HI: r = d.crc[15:8];
			default:    r = PREAMBLE;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/radio_packet_framer_crc16.sv
// Path: a request accepted into the request register moves on to the result
// register when the sequencer is free, and its first result shows from there.
// Throughput: one result per cycle while res_ready is high; a request causing n
// results (at most ten) holds the result sequencer until its last is taken.
// Requests causing no result pass at one per cycle while no burst is pending.
// Reset: arst_n clears link state (CRC to FFFF) and drops pending results.
`default_nettype none
// ---------------------------------------------------------------------------
// radio_packet_framer_crc16: byte radio packet framer / deframer, CRC-16
// Transmit builds preamble, sync, length, payload echo and CRC tail;
// receive strips length and CRC and reports frame end status.
// ---------------------------------------------------------------------------
module radio_packet_framer_crc16 import rpf_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] tx_size,
	// result channel
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      result_kind,
	output logic [7:0]      out_byte,
	output logic [2:0]      status,
	output logic [7:0]      payload_length,
	output logic            last
);

	// request register -> engine
	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] data_s1;
	logic [7:0] size_s1;
	logic       consume;

	// engine -> sequencer
	logic       load;
	logic       out_free;
	rpf_desc_t  desc;

	// The request register frees as soon as the engine takes its request,
	// which happens when the sequencer is empty or finishing its burst.
	rpf_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.data_byte  (data_byte),
		.tx_size    (tx_size),
		.consume    (consume),
		.valid_s1   (valid_s1),
		.command_s1 (command_s1),
		.data_s1    (data_s1),
		.size_s1    (size_s1)
	);

	// Link state (tx/rx flags, counters, shared CRC) advances once per
	// request; the whole burst is described by one descriptor.
	rpf_engine #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.command_s1 (command_s1),
		.data_s1    (data_s1),
		.size_s1    (size_s1),
		.out_free   (out_free),
		.consume    (consume),
		.load       (load),
		.desc       (desc)
	);

	// Burst walks slot positions: header 0..5, payload 6, tail 7..10.
	rpf_out_seq u_out_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.desc           (desc),
		.out_free       (out_free),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.result_kind    (result_kind),
		.out_byte       (out_byte),
		.status         (status),
		.payload_length (payload_length),
		.last           (last)
	);

endmodule
`default_nettype wire

>>> rtl/rpf_in_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rpf_in_reg: request input register
// Holds one request until the frame engine takes it.
// ---------------------------------------------------------------------------
module rpf_in_reg import rpf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] tx_size,
	input  wire logic       consume,
	output logic            valid_s1,
	output logic [1:0]      command_s1,
	output logic [7:0]      data_s1,
	output logic [7:0]      size_s1
);

	assign cmd_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			command_s1 <= command;
			data_s1    <= data_byte;
			size_s1    <= tx_size;
		end
	end

endmodule
`default_nettype wire

>>> rtl/rpf_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rpf_engine: framer / deframer state and decision logic
// Updates link state for one request and builds its result burst.
// ---------------------------------------------------------------------------
module rpf_engine import rpf_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire logic [1:0] command_s1,
	input  wire logic [7:0] data_s1,
	input  wire logic [7:0] size_s1,
	input  wire logic       out_free,
	output logic            consume,
	output logic            load,
	output rpf_desc_t       desc
);

	localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

	logic        tx_active_q, rx_active_q;
	logic [7:0]  byte_count_q, tx_remaining_q, frame_length_q, crc_low_seen_q;
	logic [15:0] crc_reg_q;

	logic        tx_active_d, rx_active_d;
	logic [7:0]  byte_count_d, tx_remaining_d, frame_length_d, crc_low_seen_d;
	logic [15:0] crc_reg_d;
	logic        has_res;

	logic [7:0]  eff_count;
	logic [15:0] eff_crc;
	logic [8:0]  count_nx;
	logic [15:0] crc_upd;
	logic [7:0]  rem_nx;

	assign consume   = valid_s1 && out_free;
	assign load      = consume && has_res;
	assign eff_count = rx_active_q ? byte_count_q : 8'd0;
	assign eff_crc   = rx_active_q ? crc_reg_q : CRC_INIT;
	assign count_nx  = {1'b0, eff_count} + 9'd1;
	assign crc_upd   = crc_feed(rx_active_q || tx_active_q ? crc_reg_q : CRC_INIT, data_s1);
	assign rem_nx    = (tx_remaining_q != 8'd0) ? tx_remaining_q - 8'd1 : 8'd0;

	always_comb begin
		tx_active_d    = tx_active_q;
		rx_active_d    = rx_active_q;
		byte_count_d   = byte_count_q;
		tx_remaining_d = tx_remaining_q;
		frame_length_d = frame_length_q;
		crc_low_seen_d = crc_low_seen_q;
		crc_reg_d      = crc_reg_q;
		has_res        = 1'b0;
		desc           = '0;
		desc.crc       = CRC_INIT;

		case (command_s1)
			CMD_RX_BYTE: begin
				if (tx_active_q) begin
					has_res     = 1'b1;
					desc.kind   = KIND_STATUS;
					desc.status = ST_BUSY_TX;
				end else begin
					rx_active_d  = 1'b1;
					byte_count_d = eff_count;
					crc_reg_d    = eff_crc;
					if (eff_count >= MaxLen) begin
						has_res     = 1'b1;
						desc.kind   = KIND_FEND;
						desc.status = ST_OVERFLOW;
						rx_active_d = 1'b0;
					end else if (eff_count == 8'd0) begin
						frame_length_d = data_s1;
						byte_count_d   = 8'd1;
						if (data_s1 < 8'd2) begin
							has_res     = 1'b1;
							desc.kind   = KIND_FEND;
							desc.status = ST_BAD_LEN;
							rx_active_d = 1'b0;
						end
					end else begin
						byte_count_d = count_nx[7:0];
						if (count_nx < {1'b0, frame_length_q}) begin
							crc_reg_d = crc_upd;
							has_res   = 1'b1;
							desc.kind = KIND_RX_PAY;
							desc.data = data_s1;
						end else if (count_nx == {1'b0, frame_length_q}) begin
							crc_low_seen_d = data_s1;
						end else begin
							has_res     = 1'b1;
							desc.kind   = KIND_FEND;
							desc.status = ({data_s1, crc_low_seen_q} == crc_reg_q) ?
								ST_OK : ST_CRC_ERR;
							desc.plen   = frame_length_q - 8'd2;
							rx_active_d = 1'b0;
						end
					end
				end
			end
			CMD_TX_START: begin
				has_res = 1'b1;
				if (tx_active_q) begin
					desc.kind   = KIND_STATUS;
					desc.status = ST_BUSY_TX;
				end else if (rx_active_q) begin
					desc.kind   = KIND_STATUS;
					desc.status = ST_BUSY_RX;
				end else if (size_s1 > MaxLen) begin
					desc.kind   = KIND_STATUS;
					desc.status = ST_TOO_BIG;
				end else begin
					desc.kind      = KIND_LINE;
					desc.data      = size_s1 + 8'd2;
					desc.pos_start = POS_PRE0;
					crc_reg_d      = CRC_INIT;
					if (size_s1 == 8'd0) begin
						// empty payload: header then tail in one burst
						desc.pos_end  = POS_TAIL1;
						desc.skip_pay = 1'b1;
					end else begin
						desc.pos_end   = POS_LEN;
						tx_active_d    = 1'b1;
						tx_remaining_d = size_s1;
					end
				end
			end
			CMD_TX_BYTE: begin
				if (tx_active_q) begin
					has_res        = 1'b1;
					desc.kind      = KIND_LINE;
					desc.data      = data_s1;
					desc.crc       = crc_upd;
					desc.pos_start = POS_PAY;
					if (rem_nx == 8'd0) begin
						desc.pos_end   = POS_TAIL1;
						tx_active_d    = 1'b0;
						tx_remaining_d = 8'd0;
						crc_reg_d      = CRC_INIT;
					end else begin
						desc.pos_end   = POS_PAY;
						tx_remaining_d = rem_nx;
						crc_reg_d      = crc_upd;
					end
				end
			end
			default: begin
				tx_active_d    = 1'b0;
				rx_active_d    = 1'b0;
				byte_count_d   = 8'd0;
				tx_remaining_d = 8'd0;
				frame_length_d = 8'd0;
				crc_low_seen_d = 8'd0;
				crc_reg_d      = CRC_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_active_q    <= 1'b0;
			rx_active_q    <= 1'b0;
			byte_count_q   <= 8'd0;
			tx_remaining_q <= 8'd0;
			frame_length_q <= 8'd0;
			crc_low_seen_q <= 8'd0;
			crc_reg_q      <= CRC_INIT;
		end else if (consume) begin
			tx_active_q    <= tx_active_d;
			rx_active_q    <= rx_active_d;
			byte_count_q   <= byte_count_d;
			tx_remaining_q <= tx_remaining_d;
			frame_length_q <= frame_length_d;
			crc_low_seen_q <= crc_low_seen_d;
			crc_reg_q      <= crc_reg_d;
		end
	end

	a_tx_rx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(tx_active_q && rx_active_q))
		else $error("transmit and receive active together");

	a_tx_rem: assert property (@(posedge clk) disable iff (!arst_n)
		tx_active_q |-> (tx_remaining_q != 8'd0))
		else $error("transmit active with no payload left");

	a_rx_count: assert property (@(posedge clk) disable iff (!arst_n)
		rx_active_q |-> (byte_count_q <= MaxLen))
		else $error("receive byte count past frame limit");

endmodule
`default_nettype wire

>>> rtl/rpf_out_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rpf_out_seq: result sequencer
// Holds one result burst and hands it out one result per cycle while res_ready is high.
// ---------------------------------------------------------------------------
module rpf_out_seq import rpf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire rpf_desc_t  desc,
	output logic            out_free,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      result_kind,
	output logic [7:0]      out_byte,
	output logic [2:0]      status,
	output logic [7:0]      payload_length,
	output logic            last
);

	rpf_desc_t  desc_q;
	logic [3:0] pos_q;
	logic       busy_q;
	logic       take;
	logic [3:0] pos_nx;

	assign take     = busy_q && res_ready;
	assign last     = pos_q == desc_q.pos_end;
	assign out_free = !busy_q || (take && last);
	assign pos_nx   = (pos_q == POS_LEN && desc_q.skip_pay) ? POS_CRC_LO : pos_q + 4'd1;

	assign res_valid      = busy_q;
	assign result_kind    = desc_q.kind;
	assign out_byte       = (desc_q.kind == KIND_LINE) ? line_byte(pos_q, desc_q) : desc_q.data;
	assign status         = desc_q.status;
	assign payload_length = desc_q.plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc;
			pos_q  <= desc.pos_start;
		end else if (take) begin
			pos_q  <= pos_nx;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("burst loaded over a pending one");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= desc_q.pos_end))
		else $error("result position ran past burst end");

endmodule
`default_nettype wire
